### rtl/mlab_pkg.sv
// Shared types and constants for the multi-list append buffer.
package mlab_pkg;

  localparam int NUM_LISTS     = 16;
  localparam int LIST_CAPACITY = 64;

  localparam int CMD_W    = 2;
  localparam int LIST_W   = 4;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;

  localparam int LIDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int LEN_W  = $clog2(LIST_CAPACITY + 1);
  localparam int DEPTH  = NUM_LISTS * LIST_CAPACITY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_DUMP  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ELEM  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [LIST_W-1:0]         list_index;
    logic signed [VALUE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] element_value;
    logic                      last;
  } rsp_t;

endpackage

### rtl/mlab_store.sv
// Element store: one write port, one registered read port.
module mlab_store (
  input  logic                               clk,
  input  logic                               we,
  input  logic [mlab_pkg::ADDR_W-1:0]        waddr,
  input  logic signed [mlab_pkg::VALUE_W-1:0] wdata,
  input  logic                               re,
  input  logic [mlab_pkg::ADDR_W-1:0]        raddr,
  output logic signed [mlab_pkg::VALUE_W-1:0] rdata
);
  import mlab_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/multi_list_append_buffer.sv
// Top level: sixteen append-only lists over one element store, push/dump/clear.
//
//  channel | handshake            | payload | direction
//  --------+----------------------+---------+----------
//  req     | req_valid, req_stall | req     | in
//  rsp     | rsp_valid, rsp_stall | rsp     | out
//
// Push, clear and ignored commands complete in the idle state. Overflow and
// empty-dump results go out through the emit state. A dump sends one element
// per cycle while rsp_stall is low, a rate set by the store's single read port.
// Reset clears all list lengths at once; store contents stay undefined.
// req_stall is high while an item is in progress; rsp_stall holds the
// output register and pauses the dump.
module multi_list_append_buffer (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mlab_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mlab_pkg::rsp_t rsp
);
  import mlab_pkg::*;

  state_t state, state_next;
  logic [LEN_W-1:0] lengths [NUM_LISTS];
  logic [LIDX_W-1:0] cur_idx, cur_idx_next;
  logic [LEN_W-1:0] dump_len, dump_len_next;
  logic [LEN_W-1:0] cnt, cnt_next;
  logic pend, pend_next;
  logic pend_last, pend_last_next;
  status_t emit_status, emit_status_next;
  rsp_t rsp_next;
  logic load_out;

  logic accept;
  logic in_range;
  logic [LIDX_W-1:0] in_idx;
  logic [LEN_W-1:0] cur_len;
  logic out_free;
  logic consume;
  logic issue;
  logic [LEN_W-1:0] inc_src, inc_sum;
  logic len_we;
  logic [LEN_W-1:0] len_wval;
  logic mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic signed [VALUE_W-1:0] rd_data;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign in_idx    = LIDX_W'(req.list_index);
  assign in_range  = (32'(req.list_index) < NUM_LISTS);
  assign cur_len   = lengths[in_idx];
  assign out_free  = !rsp_valid || !rsp_stall;
  assign consume   = (state == S_DUMP) && pend && out_free;
  assign issue     = (state == S_DUMP) && (cnt < dump_len) && (!pend || consume);

  // shared incrementer: list length on push, read position on dump
  assign inc_src = (state == S_DUMP) ? cnt : cur_len;
  assign inc_sum = inc_src + LEN_W'(1);

  assign mem_we = accept && in_range && (req.cmd == CMD_PUSH) &&
                  (cur_len < LEN_W'(LIST_CAPACITY));
  assign waddr  = ADDR_W'(32'(in_idx) * LIST_CAPACITY + 32'(cur_len));
  assign raddr  = ADDR_W'(32'(cur_idx) * LIST_CAPACITY + 32'(cnt));

  mlab_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (req.push_value),
    .re    (issue),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next       = state;
    cur_idx_next     = cur_idx;
    dump_len_next    = dump_len;
    cnt_next         = cnt;
    emit_status_next = emit_status;
    len_we           = 1'b0;
    len_wval         = '0;
    load_out         = 1'b0;
    rsp_next         = rsp;
    pend_next        = issue ? 1'b1 : (consume ? 1'b0 : pend);
    pend_last_next   = issue ? (inc_sum == dump_len) : pend_last;
    case (state)
      S_IDLE: begin
        if (accept && in_range) begin
          case (req.cmd)
            CMD_PUSH: begin
              if (cur_len < LEN_W'(LIST_CAPACITY)) begin
                len_we   = 1'b1;
                len_wval = inc_sum;
              end else begin
                emit_status_next = ST_FULL;
                state_next       = S_EMIT;
              end
            end
            CMD_DUMP: begin
              if (cur_len == '0) begin
                emit_status_next = ST_EMPTY;
                state_next       = S_EMIT;
              end else begin
                cur_idx_next  = in_idx;
                dump_len_next = cur_len;
                cnt_next      = '0;
                state_next    = S_DUMP;
              end
            end
            CMD_CLEAR: begin
              len_we   = 1'b1;
              len_wval = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out               = 1'b1;
          rsp_next.status        = emit_status;
          rsp_next.element_value = '0;
          rsp_next.last          = 1'b1;
          state_next             = S_IDLE;
        end
      end
      S_DUMP: begin
        if (issue) begin
          cnt_next = inc_sum;
        end
        if (consume) begin
          load_out               = 1'b1;
          rsp_next.status        = ST_ELEM;
          rsp_next.element_value = rd_data;
          rsp_next.last          = pend_last;
          if (pend_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        lengths[i] <= '0;
      end
    end else if (len_we) begin
      lengths[in_idx] <= len_wval;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx     <= cur_idx_next;
    dump_len    <= dump_len_next;
    cnt         <= cnt_next;
    pend_last   <= pend_last_next;
    emit_status <= emit_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= rsp_next;
    end
  end

  a_pend_in_dump: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_DUMP))
    else $error("read data pending outside a dump");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!rsp_valid || !rsp_stall))
    else $error("output register loaded while a transfer waits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (cnt <= dump_len))
    else $error("dump position beyond list length");

  a_issue_pend: assert property (@(posedge clk) disable iff (rst)
    issue |=> pend)
    else $error("issued read not marked pending");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    in_range |-> (cur_len <= LEN_W'(LIST_CAPACITY)))
    else $error("list length above capacity");

endmodule
